FILE: design/bapa_pkg.sv
// shared types, constants and helpers for the bitmap address pool allocator
// no dependencies; imported by bapa_engine and the top level
`default_nettype none
package bapa_pkg;

	localparam int POOL_ENTRIES = 256;
	localparam int MAP_ROWS     = (POOL_ENTRIES + 7) / 8;
	localparam int ROW_W        = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
	localparam int IDX_W        = ROW_W + 3;
	localparam int SIZE_W       = $clog2(POOL_ENTRIES + 1);

	localparam int ADDR_W       = 32;
	localparam int POOL_SIZE_W  = 9;
	localparam int STATUS_W     = 2;
	localparam int PADDR_W      = 3;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// register select is the word address bit
	localparam logic REG_BASE_ADDRESS = 1'b0;
	localparam logic REG_POOL_SIZE    = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [SIZE_W-1:0] size;
	} cfg_t;

	// lowest set bit of a map byte
	function automatic logic [2:0] lowest_set(input logic [7:0] v);
		logic [2:0] sel;
		sel = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) sel = 3'(i);
		end
		return sel;
	endfunction

endpackage
`default_nettype wire

FILE: design/bapa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module bapa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire                                          clk,
	input  wire                                          we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                             wdata,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: design/bapa_engine.sv
// sequencer, shared address adder, used-bit map and result register
// depends on bapa_pkg and bapa_ram
`default_nettype none
module bapa_engine (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  bapa_pkg::cfg_t               cfg,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                in_op,
	input  wire  [bapa_pkg::ADDR_W-1:0]        in_addr,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [bapa_pkg::ADDR_W-1:0]        out_addr,
	output logic [bapa_pkg::STATUS_W-1:0]      out_status
);
	import bapa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_GRANT,
		S_OFFSET,
		S_FETCH,
		S_CLEAR
	} state_t;

	state_t              state_q;
	logic [ROW_W-1:0]    row_q;
	logic [IDX_W-1:0]    idx_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   offset_q;
	logic [MAP_ROWS-1:0] row_valid_q;

	logic [ROW_W-1:0]    rd_row;
	logic [ROW_W-1:0]    wr_row;
	logic                wr_en;
	logic [7:0]          wr_data;
	logic [7:0]          ram_rdata;
	logic [7:0]          row_data;
	logic [ROW_W-1:0]    cur_row;
	logic [7:0]          limit;
	logic [7:0]          free_bits;
	logic [2:0]          free_sel;
	logic                last_row;
	logic [ROW_W-1:0]    off_row;
	logic [2:0]          off_bit;
	logic [ADDR_W-1:0]   add_a;
	logic [ADDR_W-1:0]   add_b;
	logic                add_cin;
	logic [ADDR_W-1:0]   add_res;

	assign off_row = offset_q[IDX_W-1:3];
	assign off_bit = offset_q[2:0];

	// one adder serves both base + index and address - base
	always_comb begin
		if (state_q == S_GRANT) begin
			add_a   = cfg.base;
			add_b   = ADDR_W'(idx_q);
			add_cin = 1'b0;
		end else begin
			add_a   = addr_q;
			add_b   = ~cfg.base;
			add_cin = 1'b1;
		end
		add_res = add_a + add_b + ADDR_W'(add_cin);
	end

	// a row never written since reset reads as all free
	assign cur_row  = (state_q == S_CLEAR) ? off_row : row_q;
	assign row_data = row_valid_q[cur_row] ? ram_rdata : 8'h00;

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			limit[b] = (ADDR_W'({row_q, 3'(b)}) < ADDR_W'(cfg.size));
		end
		free_bits = ~row_data & limit;
		free_sel  = lowest_set(free_bits);
		last_row  = (ADDR_W'({row_q, 3'b000}) + ADDR_W'(8)) >= ADDR_W'(cfg.size);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_row  = row_q;
		wr_data = row_data | (8'h01 << free_sel);
		unique case (state_q)
			S_SCAN: wr_en = |free_bits;
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_row  = off_row;
				wr_data = row_data & ~(8'h01 << off_bit);
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_SCAN:  rd_row = row_q + ROW_W'(1);
			S_FETCH: rd_row = off_row;
			default: rd_row = '0;
		endcase
	end

	bapa_ram #(
		.WIDTH(8),
		.DEPTH(MAP_ROWS)
	) u_map (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_row),
		.wdata(wr_data),
		.raddr(rd_row),
		.rdata(ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_valid_q <= '0;
			out_valid   <= 1'b0;
			row_q       <= '0;
			idx_q       <= '0;
			addr_q      <= '0;
			offset_q    <= '0;
			out_addr    <= '0;
			out_status  <= STATUS_OK;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (wr_en) row_valid_q[wr_row] <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						addr_q <= in_addr;
						row_q  <= '0;
						state_q <= (in_op == OP_RELEASE) ? S_OFFSET : S_SCAN;
					end
				end
				S_SCAN: begin
					if (|free_bits) begin
						idx_q   <= {row_q, free_sel};
						state_q <= S_GRANT;
					end else if (last_row) begin
						out_valid  <= 1'b1;
						out_addr   <= '0;
						out_status <= STATUS_FULL;
						state_q    <= S_IDLE;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				S_GRANT: begin
					out_valid  <= 1'b1;
					out_addr   <= add_res;
					out_status <= STATUS_OK;
					state_q    <= S_IDLE;
				end
				S_OFFSET: begin
					offset_q <= add_res;
					if (add_res < ADDR_W'(cfg.size)) begin
						state_q <= S_FETCH;
					end else begin
						out_valid  <= 1'b1;
						out_addr   <= '0;
						out_status <= STATUS_OUTSIDE;
						state_q    <= S_IDLE;
					end
				end
				S_FETCH: state_q <= S_CLEAR;
				S_CLEAR: begin
					out_valid  <= 1'b1;
					out_addr   <= '0;
					out_status <= STATUS_OK;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: design/bitmap_address_pool_allocator_unit.sv
// top level: apb register file, pool size clamp and stream ports
// depends on bapa_pkg and bapa_engine
`default_nettype none
// Allocates and releases addresses from a pool of consecutive addresses
// starting at base_address, tracked by one used bit per entry in a RAM of
// 8-bit rows. An allocate (tuser 0) scans the map one row per cycle, reading
// one RAM row each cycle, and grants the lowest free entry below
// min(pool_size, 256); the single RAM read port limits the scan to one row
// at a time. A full pool returns status 1 with address 0. A release (tuser 1)
// subtracts the base with the same adder that forms granted addresses, then
// does a read-modify-write of one row; an address outside the pool returns
// status 2. One result word per input word, held in an output register; the
// next word is taken once the result has been accepted. The map reads as all
// free after reset through per-row flags, so there is no clearing pass.
// Configure only while idle.
module bitmap_address_pool_allocator_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	// apb configuration port
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [bapa_pkg::PADDR_W-1:0]       paddr,
	input  wire  [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// input words
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [31:0]                        s_tdata,  // [31:0] release_address
	input  wire  [0:0]                         s_tuser,  // [0] operation
	// result words
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [31:0]                        m_tdata,  // [31:0] granted_address
	output logic [1:0]                         m_tuser   // [1:0] status
);
	import bapa_pkg::*;

	logic [ADDR_W-1:0]      base_q;
	logic [POOL_SIZE_W-1:0] pool_size_q;
	cfg_t                   cfg;
	logic                   wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			pool_size_q <= '0;
		end else if (wr_hit) begin
			unique case (paddr[2])
				REG_BASE_ADDRESS: base_q      <= pwdata;
				REG_POOL_SIZE:    pool_size_q <= pwdata[POOL_SIZE_W-1:0];
				default:          base_q      <= base_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BASE_ADDRESS: prdata = base_q;
			REG_POOL_SIZE:    prdata = 32'(pool_size_q);
			default:          prdata = '0;
		endcase
	end

	// sizes above the map depth clamp to the map depth
	always_comb begin
		cfg.base = base_q;
		if (32'(pool_size_q) > 32'(POOL_ENTRIES)) cfg.size = SIZE_W'(POOL_ENTRIES);
		else cfg.size = SIZE_W'(pool_size_q);
	end

	bapa_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser[0]),
		.in_addr   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_addr  (m_tdata),
		.out_status(m_tuser)
	);
endmodule
`default_nettype wire
